// ----- hw/rtl/ptq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_pkg - shared types and constants of the timer queue
// Field widths, command codes and the control/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ptq_pkg;

   localparam int CMD_W       = 2;
   localparam int SLOT_W      = 4;
   localparam int DELAY_W     = 16;
   localparam int TIME_W      = 32;
   localparam int DL_W        = TIME_W + 1;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_ARM_PER = 2'd1,
      CMD_ARM_ONE = 2'd2,
      CMD_DISARM  = 2'd3
   } cmd_code_type;

   // controller -> datapath
   typedef struct packed {
      logic take;        // accept a request beat
      logic apply;       // execute the latched arm or disarm
      logic scan_start;  // restart a scan from slot zero
      logic fire;        // re-arm or clear the selected slot
      logic promote;     // move the selected slot into the pending result
      logic emit;        // load the pending result into the output register
      logic emit_last;   // the emitted result closes the tick
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic req_valid;
      logic is_tick;
      logic enabled;
      logic scan_done;
      logic found;
      logic pending;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/ptq_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_ifs - channel interfaces of the timer queue
// Request, response and control-register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface ptq_req_if import ptq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [SLOT_W-1:0]   slot;
   logic [DELAY_W-1:0]  delay;
   logic [TIME_W-1:0]   now;

   modport source (output valid, cmd, slot, delay, now, input ready);
   modport sink   (input valid, cmd, slot, delay, now, output ready);
endinterface

interface ptq_rsp_if import ptq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   fired_slot;
   logic                was_periodic;
   logic                last;

   modport source (output valid, fired_slot, was_periodic, last, input ready);
   modport sink   (input valid, fired_slot, was_periodic, last, output ready);
endinterface

interface ptq_csr_if ();
   logic valid;
   logic ready;
   logic enabled;

   modport source (output valid, enabled, input ready);
   modport sink   (input valid, enabled, output ready);
endinterface

// ----- hw/rtl/periodic_oneshot_timer_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_queue_core - periodic and one-shot timer slot table
// Arm, disarm and tick commands over SLOTS timer slots; a tick returns the
// due slots in deadline order, re-arming periodic ones.
// ----------------------------------------------------------------------------
// A request beat carries one command. Arm and disarm return no response. A
// tick with the enable register set walks the slot table once per fired
// slot, through the single read port of the slot memory, and then once more
// to find nothing due, unless 16 fire; the block stalls while the response
// side holds ready low and the output register is full. Responses come one
// per fired slot, earliest deadline first, lower slot first on equal
// deadlines, and the final one of the tick carries last. At most 16 slots
// fire per tick; the rest stay due for the next one. A tick with the enable
// register clear returns nothing. The enable register is written over the
// csr channel, one beat at a time; the user must write it only while the
// block is idle, as the block itself does not enforce this. Its write is
// taken at once outside reset.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_queue_core
   import ptq_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic       clock,
   input  logic       reset,
   ptq_req_if.sink    req_bus,
   ptq_rsp_if.source  rsp_bus,
   ptq_csr_if.sink    csr_bus
);

   ctl_type ctl;
   sts_type sts;

   // sequence commands and the per-result table walks
   ptq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   // hold slot state, pick the earliest due slot, register results
   ptq_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus),
      .ctl     (ctl),
      .sts     (sts)
   );

endmodule

// ----- hw/rtl/ptq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_ctrl - timer queue sequencer
// Runs arm/disarm commands and the repeated earliest-deadline scans of a tick.
// ----------------------------------------------------------------------------
module ptq_ctrl
   import ptq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output ctl_type ctl
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_EXEC   = 5'b00010,
      S_SCAN   = 5'b00100,
      S_DECIDE = 5'b01000,
      S_FLUSH  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      ctl      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            ctl.take = 1'b1;
            if (sts.req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!sts.is_tick) begin
               ctl.apply = 1'b1;
               state_in  = S_IDLE;
            end else if (!sts.enabled) begin
               state_in = S_IDLE;
            end else begin
               ctl.scan_start = 1'b1;
               cnt_in         = '0;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (sts.scan_done) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (sts.found) begin
               // hold until the previous result can leave
               if (!sts.pending || sts.out_free) begin
                  ctl.emit    = sts.pending;
                  ctl.promote = 1'b1;
                  ctl.fire    = 1'b1;
                  cnt_in      = cnt_ff + 1'b1;
                  if (cnt_ff == CNT_W'(MAX_RESULTS - 1)) begin
                     state_in = S_FLUSH;
                  end else begin
                     ctl.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
            end else if (sts.pending) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.out_free) begin
               ctl.emit      = 1'b1;
               ctl.emit_last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- hw/rtl/ptq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptq_datapath - timer queue slot storage and selection
// Slot memories, scan pipeline, earliest-deadline tracker and result registers.
// ----------------------------------------------------------------------------
module ptq_datapath
   import ptq_pkg::*;
#(
   parameter int SLOTS = 16
) (
   input  logic           clock,
   input  logic           reset,
   ptq_req_if.sink        req_bus,
   ptq_rsp_if.source      rsp_bus,
   ptq_csr_if.sink        csr_bus,
   input  ctl_type        ctl,
   output sts_type        sts
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SW = $clog2(SLOTS + 1) + 1;

   // latched request
   logic [CMD_W-1:0]    cmd_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [DELAY_W-1:0]  delay_ff;
   logic [TIME_W-1:0]   now_ff;

   logic                enabled_ff;

   // slot state
   logic [DL_W-1:0]     deadline_mem [SLOTS];
   logic [DELAY_W-1:0]  period_mem   [SLOTS];
   logic [SLOTS-1:0]    armed_ff;
   logic [SLOTS-1:0]    per_ff;

   // scan pipeline
   logic [IW-1:0]       addr_ff, addr_in;
   logic                issuing_ff, issuing_in;
   logic                rd_valid_ff;
   logic                rd_last_ff;
   logic [IW-1:0]       rd_idx_ff;
   logic                rd_armed_ff;
   logic                rd_per_ff;
   logic [DL_W-1:0]     dl_rd_ff;
   logic [DELAY_W-1:0]  pr_rd_ff;

   // earliest due slot of the current scan
   logic                best_valid_ff;
   logic [IW-1:0]       best_idx_ff;
   logic                best_per_ff;
   logic [DL_W-1:0]     best_dl_ff;
   logic [DELAY_W-1:0]  best_pr_ff;

   // result waiting for its last flag
   logic                pend_valid_ff;
   logic [IW-1:0]       pend_idx_ff;
   logic                pend_per_ff;

   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic                rsp_per_ff;
   logic                rsp_last_ff;

   logic                slot_ok;
   logic [IW-1:0]       cmd_idx;
   logic                is_arm;
   logic                is_per;
   logic [DELAY_W-1:0]  arm_delay;
   logic [DL_W-1:0]     now_ext;
   logic                cand;
   logic                wr_en;
   logic [IW-1:0]       wr_idx;
   logic [DL_W-1:0]     wr_dl;
   logic                out_free;

   assign slot_ok   = SW'(slot_ff) < SW'(SLOTS);
   assign cmd_idx   = IW'(slot_ff);
   assign is_per    = (cmd_ff == CMD_ARM_PER);
   assign is_arm    = is_per || (cmd_ff == CMD_ARM_ONE);
   assign arm_delay = (is_per && delay_ff == '0) ? DELAY_W'(1) : delay_ff;
   assign now_ext   = {1'b0, now_ff};
   assign out_free  = !rsp_valid_ff || rsp_bus.ready;

   // due, and strictly earlier than the best so far: ties keep the lower slot
   assign cand = rd_valid_ff && rd_armed_ff && (dl_rd_ff <= now_ext)
                 && (!best_valid_ff || dl_rd_ff < best_dl_ff);

   always_comb begin
      wr_en  = 1'b0;
      wr_idx = cmd_idx;
      wr_dl  = now_ext + DL_W'(arm_delay);
      if (ctl.apply && is_arm && slot_ok) begin
         wr_en = 1'b1;
      end else if (ctl.fire && best_per_ff) begin
         wr_en  = 1'b1;
         wr_idx = best_idx_ff;
         wr_dl  = now_ext + DL_W'(best_pr_ff);
      end
   end

   always_comb begin
      addr_in    = addr_ff;
      issuing_in = issuing_ff;
      if (ctl.scan_start) begin
         addr_in    = '0;
         issuing_in = 1'b1;
      end else if (issuing_ff) begin
         addr_in = addr_ff + 1'b1;
         if (addr_ff == IW'(SLOTS - 1)) begin
            issuing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.take && req_bus.valid) begin
         cmd_ff   <= req_bus.cmd;
         slot_ff  <= req_bus.slot;
         delay_ff <= req_bus.delay;
         now_ff   <= req_bus.now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         enabled_ff <= csr_bus.enabled;
      end
   end

   // slot memories: one write port, one registered scan read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         deadline_mem[wr_idx] <= wr_dl;
      end
      if (ctl.apply && is_arm && slot_ok) begin
         period_mem[cmd_idx] <= is_per ? arm_delay : '0;
      end
      if (issuing_ff) begin
         dl_rd_ff <= deadline_mem[addr_ff];
         pr_rd_ff <= period_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
         per_ff   <= '0;
      end else if (ctl.apply && slot_ok) begin
         if (is_arm) begin
            armed_ff[cmd_idx] <= 1'b1;
            per_ff[cmd_idx]   <= is_per;
         end else if (cmd_ff == CMD_DISARM) begin
            armed_ff[cmd_idx] <= 1'b0;
         end
      end else if (ctl.fire && !best_per_ff) begin
         armed_ff[best_idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff     <= '0;
         issuing_ff  <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         addr_ff     <= addr_in;
         issuing_ff  <= issuing_in;
         rd_valid_ff <= issuing_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issuing_ff) begin
         rd_idx_ff   <= addr_ff;
         rd_last_ff  <= (addr_ff == IW'(SLOTS - 1));
         rd_armed_ff <= armed_ff[addr_ff];
         rd_per_ff   <= per_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_valid_ff <= 1'b0;
      end else if (ctl.scan_start) begin
         best_valid_ff <= 1'b0;
      end else if (cand) begin
         best_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cand) begin
         best_idx_ff <= rd_idx_ff;
         best_per_ff <= rd_per_ff;
         best_dl_ff  <= dl_rd_ff;
         best_pr_ff  <= pr_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (ctl.promote) begin
         pend_valid_ff <= 1'b1;
      end else if (ctl.emit_last) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.promote) begin
         pend_idx_ff <= best_idx_ff;
         pend_per_ff <= best_per_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.emit) begin
         rsp_slot_ff <= SLOT_W'(pend_idx_ff);
         rsp_per_ff  <= pend_per_ff;
         rsp_last_ff <= ctl.emit_last;
      end
   end

   // refuse beats while reset is held
   assign req_bus.ready        = ctl.take && !reset;
   assign csr_bus.ready        = !reset;
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.fired_slot   = rsp_slot_ff;
   assign rsp_bus.was_periodic = rsp_per_ff;
   assign rsp_bus.last         = rsp_last_ff;

   assign sts.req_valid = req_bus.valid;
   assign sts.is_tick   = (cmd_ff == CMD_TICK);
   assign sts.enabled   = enabled_ff;
   assign sts.scan_done = rd_valid_ff && rd_last_ff;
   assign sts.found     = best_valid_ff;
   assign sts.pending   = pend_valid_ff;
   assign sts.out_free  = out_free;

endmodule

// ----- tb/tb_periodic_oneshot_timer_queue_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_oneshot_timer_queue_core - self-checking bench for the timer queue
// Drives arm, disarm and tick commands through the request channel and keeps
// its own slot table. Every tick's fired-slot beats are predicted on request
// acceptance and compared field by field with the response channel, while both
// sides idle at random and the enable register is toggled between phases.
// ----------------------------------------------------------------------------
module tb_periodic_oneshot_timer_queue_core;
   import ptq_pkg::*;

   localparam int SLOTS          = 16;
   localparam int HALF_PERIOD    = 10;
   // a tick that finds nothing due still walks the table once; allow for a
   // few such walks before touching the enable register or ending the run
   localparam int DRAIN_CYCLES   = 4 * (SLOTS + 2);
   localparam int END_WAIT_LIMIT = 20000;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              periodic;
      logic              last;
   } fire_rec_type;

   // receiver behavior, redrawn at random by the response-side stall process
   typedef enum int {
      STALL_NONE,
      STALL_HALF,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset;

   ptq_req_if req_if ();
   ptq_rsp_if rsp_if ();
   ptq_csr_if csr_if ();

   periodic_oneshot_timer_queue_core #(
      .SLOTS (SLOTS)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // shadow copy of the slot table and the enable register
   logic               slot_armed    [SLOTS];
   logic               slot_periodic [SLOTS];
   logic [DELAY_W-1:0] slot_period   [SLOTS];
   logic [DL_W-1:0]    slot_deadline [SLOTS];
   logic               enable_shadow;

   // fired-slot beats still owed by the block, oldest first
   fire_rec_type pending_fires [$];

   int             err_count     = 0;
   int             beats_checked = 0;
   int             cmds_sent     = 0;
   int             ticks_sent    = 0;
   int             enable_writes = 0;
   int             burst_left    = 0;
   int             stall_cycle   = 0;
   stall_mode_type stall_mode    = STALL_NONE;
   logic [TIME_W-1:0] wall_time;

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Slot table predictor: update the shadow state for one accepted command
   // and queue the beats a tick is expected to produce.
   // -------------------------------------------------------------------------
   function automatic void predict_command(input logic [CMD_W-1:0]   c,
                                           input logic [SLOT_W-1:0]  s,
                                           input logic [DELAY_W-1:0] d,
                                           input logic [TIME_W-1:0]  t);
      bit                 taken [SLOTS];
      int                 order [MAX_RESULTS];
      fire_rec_type       rec;
      logic [DELAY_W-1:0] interval;
      int                 best;
      int                 n;
      int                 i;
      int                 j;

      case (c)
         CMD_ARM_PER, CMD_ARM_ONE: begin
            // a periodic interval of zero would fire forever; raise it to one
            interval = (c == CMD_ARM_PER && d == '0) ? DELAY_W'(1) : d;
            slot_armed[s]    = 1'b1;
            slot_periodic[s] = (c == CMD_ARM_PER);
            slot_period[s]   = interval;
            slot_deadline[s] = {1'b0, t} + interval;
         end
         CMD_DISARM: begin
            slot_armed[s] = 1'b0;
         end
         default: begin
            if (enable_shadow) begin
               for (i = 0; i < SLOTS; i++)
                  taken[i] = 1'b0;
               n    = 0;
               best = 0;
               // pick due slots earliest deadline first, lower slot on ties
               while (n < MAX_RESULTS && best >= 0) begin
                  best = -1;
                  for (i = 0; i < SLOTS; i++) begin
                     if (slot_armed[i] && !taken[i]
                         && slot_deadline[i] <= {1'b0, t}) begin
                        if (best < 0 || slot_deadline[i] < slot_deadline[best])
                           best = i;
                     end
                  end
                  if (best >= 0) begin
                     taken[best] = 1'b1;
                     order[n]    = best;
                     n++;
                  end
               end
               // queue the beats in firing order, last flag on the final one
               for (j = 0; j < n; j++) begin
                  rec.slot     = SLOT_W'(order[j]);
                  rec.periodic = slot_periodic[order[j]];
                  rec.last     = (j == n - 1);
                  pending_fires.insert(pending_fires.size(), rec);
               end
               // re-arm or clear only after selection is complete
               for (i = 0; i < SLOTS; i++) begin
                  if (taken[i]) begin
                     if (slot_periodic[i])
                        slot_deadline[i] = {1'b0, t} + slot_period[i];
                     else
                        slot_armed[i] = 1'b0;
                  end
               end
            end
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Request sender: bursts of random length, most of them opened by a gap.
   // Valid stays high from one beat to the next inside a burst.
   // -------------------------------------------------------------------------
   task automatic send_command(input logic [CMD_W-1:0]   c,
                               input logic [SLOT_W-1:0]  s,
                               input logic [DELAY_W-1:0] d,
                               input logic [TIME_W-1:0]  t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         // leave a quarter of the bursts back to back with the previous one
         if ($urandom_range(0, 3) != 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.cmd   <= c;
      req_if.slot  <= s;
      req_if.delay <= d;
      req_if.now   <= t;
      do
         @(posedge clock);
      while (!req_if.ready);
      predict_command(c, s, d, t);
      cmds_sent++;
      if (c == CMD_TICK)
         ticks_sent++;
   endtask

   // -------------------------------------------------------------------------
   // Enable register write: hold requests, let every owed beat arrive and the
   // last walk finish, then issue one csr beat.
   // -------------------------------------------------------------------------
   task automatic write_enable(input logic value);
      req_if.valid <= 1'b0;
      while (pending_fires.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_if.valid   <= 1'b1;
      csr_if.enabled <= value;
      do
         @(posedge clock);
      while (!csr_if.ready);
      csr_if.valid  <= 1'b0;
      enable_shadow = value;
      enable_writes++;
   endtask

   // -------------------------------------------------------------------------
   // Response side: stall pattern and beat checker
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 150 == 0)
         stall_mode = stall_mode_type'($urandom_range(STALL_NONE, STALL_PERIODIC));
      case (stall_mode)
         STALL_NONE:  rsp_if.ready <= 1'b1;
         STALL_HALF:  rsp_if.ready <= 1'($urandom_range(0, 1));
         STALL_HEAVY: rsp_if.ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_if.ready <= (stall_cycle % 7) < 3;
      endcase
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : check_fired
      fire_rec_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_fires.size() == 0) begin
            $display("%0t ns: unexpected beat, expected none, %s %0d periodic %0b last %0b",
                     $time, "actual slot", rsp_if.fired_slot, rsp_if.was_periodic,
                     rsp_if.last);
            err_count++;
         end else begin
            want = pending_fires.pop_front();
            beats_checked++;
            check_field("fired_slot", 32'(want.slot), 32'(rsp_if.fired_slot));
            check_field("was_periodic", 32'(want.periodic), 32'(rsp_if.was_periodic));
            check_field("last", 32'(want.last), 32'(rsp_if.last));
         end
      end
   end

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Ticks with the enable register clear fire nothing and leave slots alone;
   // a periodic arm with interval zero comes due one unit later.
   task automatic test_disabled_tick();
      write_enable(1'b0);
      send_command(CMD_ARM_PER, 4'd0, 16'd0, 32'd0);
      send_command(CMD_TICK, 4'd0, 16'd0, 32'd5);
      write_enable(1'b1);
      send_command(CMD_TICK, 4'd0, 16'd0, 32'd5);
   endtask

   // Re-arm replaces the old deadline; equal deadlines fire lower slot first;
   // disarm of an idle slot is harmless; time may run backwards.
   task automatic test_rearm_and_order();
      send_command(CMD_ARM_ONE, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
      send_command(CMD_ARM_ONE, 4'd7, 16'd0, 32'd10);
      send_command(CMD_ARM_ONE, 4'd7, 16'd3, 32'd10);
      send_command(CMD_TICK, 4'd0, 16'd0, 32'd12);
      send_command(CMD_ARM_PER, 4'd2, 16'd4, 32'd8);
      send_command(CMD_ARM_ONE, 4'd9, 16'd2, 32'd10);
      send_command(CMD_ARM_ONE, 4'd4, 16'd0, 32'd12);
      send_command(CMD_DISARM, 4'd5, 16'd0, 32'd0);
      send_command(CMD_TICK, 4'd15, 16'hFFFF, 32'd13);
      send_command(CMD_DISARM, 4'd2, 16'd0, 32'd0);
      send_command(CMD_TICK, 4'd0, 16'd0, 32'd0);
   endtask

   // A deadline at the top of the time range still fires; deadlines that land
   // past the top never come due.
   task automatic test_time_extremes();
      send_command(CMD_TICK, 4'd0, 16'd0, 32'hFFFF_FFFF);
      send_command(CMD_ARM_PER, 4'd1, 16'hFFFF, 32'hFFFF_0000);
      send_command(CMD_TICK, 4'd0, 16'd0, 32'hFFFF_FFFF);
   endtask

   // Every slot due on one tick: sixteen beats, one-shots at the earlier
   // deadline first, then the periodic ones.
   task automatic test_full_table();
      int i;
      for (i = 0; i < SLOTS; i++) begin
         if (i % 2 == 0)
            send_command(CMD_ARM_ONE, SLOT_W'(i), 16'd0, 32'd1000);
         else
            send_command(CMD_ARM_PER, SLOT_W'(i), 16'd0, 32'd1000);
      end
      send_command(CMD_TICK, 4'd0, 16'd0, 32'd1001);
   endtask

   // Mostly well-formed traffic around a running time base, with some noise
   // times, backward steps and full-range delays mixed in.
   task automatic test_random_phase(input int count, input logic [TIME_W-1:0] start,
                                    input logic enable);
      int                 pick;
      logic [CMD_W-1:0]   c;
      logic [SLOT_W-1:0]  s;
      logic [DELAY_W-1:0] d;
      logic [TIME_W-1:0]  t;

      write_enable(enable);
      wall_time = start;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            c         = CMD_TICK;
            wall_time = wall_time + $urandom_range(0, 6);
         end else if (pick < 65) begin
            c = CMD_ARM_PER;
         end else if (pick < 88) begin
            c = CMD_ARM_ONE;
         end else begin
            c = CMD_DISARM;
         end
         s = SLOT_W'($urandom_range(0, SLOTS - 1));
         d = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom())
                                         : DELAY_W'($urandom_range(0, 12));
         t = wall_time;
         if ($urandom_range(0, 15) == 0)
            t = $urandom();
         else if ($urandom_range(0, 15) == 0)
            t = wall_time - $urandom_range(0, 20);
         send_command(c, s, d, t);
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin : run_tests
      int waited;

      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.cmd     = CMD_TICK;
      req_if.slot    = '0;
      req_if.delay   = '0;
      req_if.now     = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.enabled = 1'b0;
      enable_shadow  = 1'b0;
      wall_time      = '0;
      for (int i = 0; i < SLOTS; i++) begin
         slot_armed[i]    = 1'b0;
         slot_periodic[i] = 1'b0;
         slot_period[i]   = '0;
         slot_deadline[i] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_disabled_tick();
      test_rearm_and_order();
      test_time_extremes();
      test_full_table();
      test_random_phase(90, TIME_W'($urandom_range(0, 1000)), 1'b1);
      test_random_phase(30, $urandom(), 1'b0);
      test_random_phase(80, $urandom(), 1'b1);
      test_random_phase(70, 32'hFFFF_FF80, 1'b1);
      test_random_phase(80, TIME_W'($urandom_range(0, 5000)), 1'b1);

      // drop valid, wait for the owed beats, then let the last walk finish
      req_if.valid <= 1'b0;
      waited = 0;
      while (pending_fires.size() != 0 && waited < END_WAIT_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_fires.size() != 0) begin
         $display("%0t ns: %0d expected fired-slot beats never arrived",
                  $time, pending_fires.size());
         err_count += pending_fires.size();
      end

      $display("Run covered %0d commands (%0d ticks) and %0d fired-slot beats,",
               cmds_sent, ticks_sent, beats_checked);
      $display("with %0d enable writes and %0d mismatches.", enable_writes, err_count);
      if (err_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("%0t ns: timeout, %0d beats still expected", $time, pending_fires.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
